// ===== sv/gpad_poll_pkg.sv =====
// Package with the frame constants and transmit byte tables of the gamepad poll sequencer.
package gpad_poll_pkg;

    localparam int POLL_FRAME_BYTES = 9;
    localparam int BYTE_POS_W = ($clog2(POLL_FRAME_BYTES) > 4) ? $clog2(POLL_FRAME_BYTES) : 4;

    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    // Start commands carried with each tick.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_POLL = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;

    // Frame numbers within an init sequence.
    localparam logic [1:0] FR_POLL  = 2'd0;
    localparam logic [1:0] FR_ENTER = 2'd1;
    localparam logic [1:0] FR_LOCK  = 2'd2;
    localparam logic [1:0] FR_EXIT  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANALOG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_LOCK  = 3'd4;

    localparam logic [7:0] BYTE_HEADER = 8'h01;
    localparam logic [7:0] BYTE_POLL   = 8'h42;
    localparam logic [7:0] BYTE_CONFIG = 8'h43;
    localparam logic [7:0] BYTE_MODE   = 8'h44;
    localparam logic [7:0] BYTE_EXIT   = 8'h5A;

    // Position of the final byte of a frame.
    function automatic logic [BYTE_POS_W-1:0] frame_last_idx(input logic [1:0] frame);
        logic [BYTE_POS_W-1:0] idx;
        case (frame)
            FR_POLL:  idx = BYTE_POS_W'(POLL_FRAME_BYTES - 1);
            FR_ENTER: idx = BYTE_POS_W'(4);
            default:  idx = BYTE_POS_W'(8);
        endcase
        return idx;
    endfunction

    function automatic logic [7:0] tx_byte(input logic [1:0]            frame,
                                           input logic [BYTE_POS_W-1:0] pos,
                                           input logic [7:0]            analog,
                                           input logic [7:0]            lock);
        logic [7:0] b;
        b = 8'h00;
        if (pos == BYTE_POS_W'(0)) begin
            b = BYTE_HEADER;
        end else if (pos == BYTE_POS_W'(1)) begin
            case (frame)
                FR_POLL: b = BYTE_POLL;
                FR_LOCK: b = BYTE_MODE;
                default: b = BYTE_CONFIG;
            endcase
        end else begin
            case (frame)
                FR_ENTER: b = (pos == BYTE_POS_W'(3)) ? 8'h01 : 8'h00;
                FR_LOCK:
                begin
                    if (pos == BYTE_POS_W'(3)) begin
                        b = analog;
                    end else if (pos == BYTE_POS_W'(4)) begin
                        b = lock;
                    end
                end
                FR_EXIT: b = (pos >= BYTE_POS_W'(4)) ? BYTE_EXIT : 8'h00;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// ===== sv/gamepad_serial_poll_sequencer.sv =====
// Top level of the gamepad serial poll sequencer: link state machine and result register.
// Each accepted input request is one timing tick of the controller link and produces
// exactly one result request with the pin levels after that tick and, when a byte
// completes, the received byte with its frame and position. The block takes one tick
// per clock cycle while the result register is empty or read out: the whole tick update
// is a single pass of logic from the state registers into the result register, and a
// new tick is accepted while the previous result waits as long as the downstream side is
// ready in the same cycle. A start command on operation (poll frame or four-frame init
// sequence) is honored only while the link is idle. Configuration writes are accepted
// in any cycle and should be made while the link is idle.
module gamepad_serial_poll_sequencer
    import gpad_poll_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // [0] data_pin, [7:1] zero
    input  logic [S_USER_W-1:0]   s_axis_tuser,   // [1:0] operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] clock_pin, [1] command_pin, [2] attention_pin, [3] busy_res, [4] rx_valid,
    // [6:5] rx_frame, [10:7] rx_index, [18:11] rx_byte, [23:19] zero
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    output logic                  m_axis_tlast,   // frame_last
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_LOW,
        PH_HIGH,
        PH_GAP,
        PH_END
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [1:0]            frame_reg, frame_next;
    logic                  init_reg, init_next;
    logic [BYTE_POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [2:0]            bit_pos_reg, bit_pos_next;
    logic [7:0]            tick_reg, tick_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  clk_lvl_reg, clk_lvl_next;
    logic                  cmd_lvl_reg, cmd_lvl_next;
    logic                  att_lvl_reg, att_lvl_next;

    logic [7:0] clock_low_reg, clock_high_reg, byte_gap_reg, analog_reg, lock_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic                  s_accept;
    logic [1:0]            operation;
    logic                  data_pin;
    logic [7:0]            low_thresh, high_thresh;
    logic                  byte_more;
    logic [BYTE_POS_W-1:0] byte_pos_inc;
    logic [7:0]            cur_tx, nxt_tx;
    logic [7:0]            sampled;
    logic                  rv, rl;
    logic [1:0]            rf;
    logic [3:0]            ri;
    logic [7:0]            rb;

    assign operation = s_axis_tuser[1:0];
    assign data_pin  = s_axis_tdata[0];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign low_thresh   = (clock_low_reg == 8'd0) ? 8'd1 : clock_low_reg;
    assign high_thresh  = (clock_high_reg == 8'd0) ? 8'd1 : clock_high_reg;
    assign byte_more    = byte_pos_reg != frame_last_idx(frame_reg);
    assign byte_pos_inc = byte_pos_reg + BYTE_POS_W'(1);
    assign cur_tx       = tx_byte(frame_reg, byte_pos_reg, analog_reg, lock_reg);
    assign nxt_tx       = tx_byte(frame_reg, byte_pos_inc, analog_reg, lock_reg);
    assign sampled      = shift_reg | (8'(data_pin) << bit_pos_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        frame_next    = frame_reg;
        init_next     = init_reg;
        byte_pos_next = byte_pos_reg;
        bit_pos_next  = bit_pos_reg;
        tick_next     = tick_reg;
        shift_next    = shift_reg;
        clk_lvl_next  = clk_lvl_reg;
        cmd_lvl_next  = cmd_lvl_reg;
        att_lvl_next  = att_lvl_reg;
        rv = 1'b0;
        rf = 2'd0;
        ri = 4'd0;
        rb = 8'd0;
        rl = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                clk_lvl_next = 1'b1;
                cmd_lvl_next = 1'b1;
                att_lvl_next = 1'b1;
                if (operation == OP_POLL || operation == OP_INIT) begin
                    init_next     = (operation == OP_INIT);
                    frame_next    = FR_POLL;
                    byte_pos_next = '0;
                    bit_pos_next  = 3'd0;
                    shift_next    = 8'd0;
                    tick_next     = 8'd0;
                    att_lvl_next  = 1'b0;
                    phase_next    = PH_START;
                end
            end
            PH_START:
            begin
                // First bit of byte zero; every frame opens with the header byte.
                att_lvl_next  = 1'b0;
                byte_pos_next = '0;
                bit_pos_next  = 3'd0;
                shift_next    = 8'd0;
                cmd_lvl_next  = BYTE_HEADER[0];
                clk_lvl_next  = 1'b0;
                tick_next     = 8'd1;
                phase_next    = PH_LOW;
            end
            PH_LOW:
            begin
                if (tick_reg >= low_thresh) begin
                    shift_next   = sampled;
                    clk_lvl_next = 1'b1;
                    tick_next    = 8'd1;
                    phase_next   = PH_HIGH;
                    if (bit_pos_reg == 3'd7) begin
                        rv = 1'b1;
                        rf = frame_reg;
                        ri = byte_pos_reg[3:0];
                        rb = sampled;
                        rl = (!init_reg || frame_reg == FR_EXIT) && !byte_more;
                    end
                end else begin
                    tick_next = tick_reg + 8'd1;
                end
            end
            PH_HIGH:
            begin
                if (tick_reg >= high_thresh) begin
                    if (bit_pos_reg != 3'd7) begin
                        bit_pos_next = bit_pos_reg + 3'd1;
                        cmd_lvl_next = cur_tx[bit_pos_reg + 3'd1];
                        clk_lvl_next = 1'b0;
                        tick_next    = 8'd1;
                        phase_next   = PH_LOW;
                    end else begin
                        shift_next   = 8'd0;
                        clk_lvl_next = 1'b1;
                        cmd_lvl_next = 1'b1;
                        if (byte_gap_reg != 8'd0) begin
                            tick_next  = 8'd1;
                            phase_next = PH_GAP;
                        end else if (byte_more) begin
                            byte_pos_next = byte_pos_inc;
                            bit_pos_next  = 3'd0;
                            cmd_lvl_next  = nxt_tx[0];
                            clk_lvl_next  = 1'b0;
                            tick_next     = 8'd1;
                            phase_next    = PH_LOW;
                        end else begin
                            att_lvl_next = 1'b1;
                            phase_next   = PH_END;
                        end
                    end
                end else begin
                    tick_next = tick_reg + 8'd1;
                end
            end
            PH_GAP:
            begin
                if (tick_reg >= byte_gap_reg) begin
                    clk_lvl_next = 1'b1;
                    cmd_lvl_next = 1'b1;
                    if (byte_more) begin
                        byte_pos_next = byte_pos_inc;
                        bit_pos_next  = 3'd0;
                        cmd_lvl_next  = nxt_tx[0];
                        clk_lvl_next  = 1'b0;
                        tick_next     = 8'd1;
                        phase_next    = PH_LOW;
                    end else begin
                        att_lvl_next = 1'b1;
                        phase_next   = PH_END;
                    end
                end else begin
                    tick_next = tick_reg + 8'd1;
                end
            end
            PH_END:
            begin
                if (init_reg && frame_reg != FR_EXIT) begin
                    frame_next   = frame_reg + 2'd1;
                    tick_next    = 8'd0;
                    att_lvl_next = 1'b0;
                    cmd_lvl_next = 1'b1;
                    clk_lvl_next = 1'b1;
                    phase_next   = PH_START;
                end else begin
                    att_lvl_next = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                clk_lvl_next = 1'b1;
                cmd_lvl_next = 1'b1;
                att_lvl_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (s_accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0, rb, ri, rf, rv, (phase_next != PH_IDLE),
                              att_lvl_next, cmd_lvl_next, clk_lvl_next};
            out_last_next  = rl;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_IDLE;
            frame_reg      <= 2'd0;
            init_reg       <= 1'b0;
            byte_pos_reg   <= '0;
            bit_pos_reg    <= 3'd0;
            tick_reg       <= 8'd0;
            shift_reg      <= 8'd0;
            clk_lvl_reg    <= 1'b1;
            cmd_lvl_reg    <= 1'b1;
            att_lvl_reg    <= 1'b1;
            clock_low_reg  <= 8'd4;
            clock_high_reg <= 8'd1;
            byte_gap_reg   <= 8'd3;
            analog_reg     <= 8'd1;
            lock_reg       <= 8'd3;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg    <= phase_next;
                frame_reg    <= frame_next;
                init_reg     <= init_next;
                byte_pos_reg <= byte_pos_next;
                bit_pos_reg  <= bit_pos_next;
                tick_reg     <= tick_next;
                shift_reg    <= shift_next;
                clk_lvl_reg  <= clk_lvl_next;
                cmd_lvl_reg  <= cmd_lvl_next;
                att_lvl_reg  <= att_lvl_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CLOCK_LOW:  clock_low_reg  <= cfg_data;
                    REG_CLOCK_HIGH: clock_high_reg <= cfg_data;
                    REG_BYTE_GAP:   byte_gap_reg   <= cfg_data;
                    REG_ANALOG:     analog_reg     <= cfg_data;
                    REG_MODE_LOCK:  lock_reg       <= cfg_data;
                    default:        ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // A byte is reported on the tick the data pin is sampled, when the clock rises.
    a_rx_clock_high: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[0])
        else $error("received byte reported while clock is low");

    // Attention is only ever low while a frame is in progress.
    a_att_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[2]) |-> m_axis_tdata[3])
        else $error("attention low while idle");

    // The idle link holds every pin high.
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (clk_lvl_reg && cmd_lvl_reg && att_lvl_reg))
        else $error("link pins not high while idle");

    // A start taken while idle always opens a frame.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && phase_reg == PH_IDLE && (operation == OP_POLL || operation == OP_INIT))
        |=> (phase_reg == PH_START && !att_lvl_reg))
        else $error("start request did not open a frame");

    // The last byte flag only accompanies a received byte.
    a_last_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[4])
        else $error("last flag without a received byte");
`endif

endmodule
